// ===== src/afk_pkg.sv =====
// Shared types, constants and fixed-point helpers for the arm forward kinematics block.
// No dependencies; used by afk_cordic, afk_pose and arm_forward_kinematics_5dof.
`default_nettype none
package afk_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int QW           = 34;   // Q30 values with headroom
    localparam int PW           = 52;   // length times Q30 sums
    localparam int POS_WIDTH    = 18;
    localparam int CFG_IDX_W    = 8;
    localparam int LEN_W        = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REACH  = 8'd1;

    localparam logic [LEN_W-1:0] OFFSET_RESET = 16'd10240;
    localparam logic [LEN_W-1:0] REACH_RESET  = 16'd39117;

    localparam logic signed [QW-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef logic signed [QW-1:0] q_t;
    typedef logic signed [PW-1:0] pw_t;
    typedef logic [LEN_W-1:0]     len_t;

    // Sine and cosine of one joint
    typedef struct packed {
        q_t s;
        q_t c;
    } sc_t;

    // Unrounded pose: nine rotation terms and three position sums
    typedef struct packed {
        q_t  [8:0] o;
        pw_t [2:0] p;
    } raw_t;

    // Product of two Q30 values, rounded back to Q30
    function automatic q_t qmul(input q_t a, input q_t b);
        logic signed [2*QW-1:0] aw;
        logic signed [2*QW-1:0] bw;
        logic signed [2*QW-1:0] pr;
        aw = (2*QW)'(a);
        bw = (2*QW)'(b);
        pr = aw * bw + ((2*QW)'(1) <<< 29);
        return pr[QW+29:30];
    endfunction

    // Unsigned length times Q30 value
    function automatic pw_t lmul(input len_t l, input q_t q);
        pw_t lw;
        pw_t qw;
        lw = PW'({1'b0, l});
        qw = PW'(q);
        return lw * qw;
    endfunction

    // CORDIC arctangent table, 2^32 is a full turn
    function automatic logic [31:0] arc_angle(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/afk_cordic.sv =====
// One sine/cosine lane: pipelined rotation-mode CORDIC, one iteration per stage.
// Depends on afk_pkg. The input register, the iteration stages and the output register advance only while en is high.
`default_nettype none
module afk_cordic #(
    parameter int ANGLE_BITS = 16
) (
    input  wire                          aclk,
    input  wire                          en,
    input  wire logic [ANGLE_BITS-1:0]   angle,
    output afk_pkg::sc_t                 sc
);

    localparam int N = afk_pkg::CORDIC_STEPS;

    afk_pkg::q_t  x_reg [0:N];
    afk_pkg::q_t  y_reg [0:N];
    logic [31:0]  z_reg [0:N];
    logic [N:0]   flip_reg;
    afk_pkg::sc_t sc_reg;

    logic [31:0] z_in;
    logic        flip_in;

    // Widen to a 32-bit binary angle; fold quadrants two and three by pi
    assign z_in    = {angle, {(32-ANGLE_BITS){1'b0}}};
    assign flip_in = z_in[31] ^ z_in[30];

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= afk_pkg::CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= {z_in[31] ^ flip_in, z_in[30:0]};
            flip_reg[0] <= flip_in;
        end
    end

    // Iteration stages
    for (genvar g = 0; g < N; g++) begin : g_iter
        afk_pkg::q_t dx;
        afk_pkg::q_t dy;
        logic [31:0] arc;
        assign dx  = x_reg[g] >>> g;
        assign dy  = y_reg[g] >>> g;
        assign arc = afk_pkg::arc_angle(5'(g));
        always_ff @(posedge aclk) begin
            if (en) begin
                if (z_reg[g][31]) begin
                    x_reg[g+1] <= x_reg[g] + dy;
                    y_reg[g+1] <= y_reg[g] - dx;
                    z_reg[g+1] <= z_reg[g] + arc;
                end else begin
                    x_reg[g+1] <= x_reg[g] - dy;
                    y_reg[g+1] <= y_reg[g] + dx;
                    z_reg[g+1] <= z_reg[g] - arc;
                end
                flip_reg[g+1] <= flip_reg[g];
            end
        end
    end

    // Undo the pi fold
    always_ff @(posedge aclk) begin
        if (en) begin
            sc_reg.c <= flip_reg[N] ? -x_reg[N] : x_reg[N];
            sc_reg.s <= flip_reg[N] ? -y_reg[N] : y_reg[N];
        end
    end

    assign sc = sc_reg;

    // z of the last stage is residual angle only
    logic unused_z;
    assign unused_z = ^z_reg[N];

endmodule
`default_nettype wire

// ===== src/afk_pose.sv =====
// Merging stage: combines the five lanes' sine/cosine into rotation terms and position.
// Depends on afk_pkg. Four enabled pipeline stages, one rounded product per path.
`default_nettype none
module afk_pose (
    input  wire                aclk,
    input  wire                en,
    input  wire afk_pkg::sc_t  lane [0:4],
    input  wire afk_pkg::len_t offset_len,
    input  wire afk_pkg::len_t reach_len,
    output afk_pkg::raw_t      raw
);

    typedef afk_pkg::q_t q_t;
    typedef afk_pkg::pw_t pw_t;

    q_t s1, c1, s2, c2, s3, c3, s4, c4, s5, c5;
    assign {s1, c1} = lane[0];
    assign {s2, c2} = lane[1];
    assign {s3, c3} = lane[2];
    assign {s4, c4} = lane[3];
    assign {s5, c5} = lane[4];

    // Stage 1: pairwise products
    q_t c1c2_reg, c2c3_reg, c2s1_reg, c3c4_reg, c1s2_reg, s1s2_reg, s2s3_reg;
    q_t c5s2_reg, c1c4_reg, c4s1_reg, c3s2_reg;
    q_t s1s3_reg, c3s1_reg, c1s3_reg, c1c3_reg, c2s4_reg, c2c4_reg;
    q_t a_s1_reg, a_s3_reg, a_c3_reg, a_s2_reg, a_s4_reg, a_c4_reg, a_s5_reg, a_c5_reg;
    pw_t pz_a_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            c1c2_reg <= afk_pkg::qmul(c1, c2);
            c2c3_reg <= afk_pkg::qmul(c2, c3);
            c2s1_reg <= afk_pkg::qmul(c2, s1);
            c3c4_reg <= afk_pkg::qmul(c3, c4);
            c1s2_reg <= afk_pkg::qmul(c1, s2);
            s1s2_reg <= afk_pkg::qmul(s1, s2);
            s2s3_reg <= afk_pkg::qmul(s2, s3);
            c5s2_reg <= afk_pkg::qmul(c5, s2);
            c1c4_reg <= afk_pkg::qmul(c1, c4);
            c4s1_reg <= afk_pkg::qmul(c4, s1);
            c3s2_reg <= afk_pkg::qmul(c3, s2);
            s1s3_reg <= afk_pkg::qmul(s1, s3);
            c3s1_reg <= afk_pkg::qmul(c3, s1);
            c1s3_reg <= afk_pkg::qmul(c1, s3);
            c1c3_reg <= afk_pkg::qmul(c1, c3);
            c2s4_reg <= afk_pkg::qmul(c2, s4);
            c2c4_reg <= afk_pkg::qmul(c2, c4);
            a_s1_reg <= s1;
            a_s3_reg <= s3;
            a_c3_reg <= c3;
            a_s2_reg <= s2;
            a_s4_reg <= s4;
            a_c4_reg <= c4;
            a_s5_reg <= s5;
            a_c5_reg <= c5;
            pz_a_reg <= afk_pkg::lmul(reach_len, c2) + afk_pkg::lmul(offset_len, s2);
        end
    end

    // Stage 2: triple products and first sums
    q_t ta_reg, tb_reg, tc_reg, td_reg, te_reg;
    q_t c1s2s4_reg, s1s2s4_reg, s2s3s5_reg, c5s2s3_reg, c1c4s2_reg, c4s1s2_reg, o8_b_reg;
    q_t b_s4_reg, b_c4_reg, b_s5_reg, b_c5_reg;
    pw_t px_b_reg, py_b_reg, pz_b_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ta_reg     <= s1s3_reg - afk_pkg::qmul(c1c2_reg, a_c3_reg);
            tb_reg     <= c3s1_reg + afk_pkg::qmul(c1c2_reg, a_s3_reg);
            tc_reg     <= c1s3_reg + afk_pkg::qmul(c2c3_reg, a_s1_reg);
            td_reg     <= c1c3_reg - afk_pkg::qmul(c2s1_reg, a_s3_reg);
            te_reg     <= c2s4_reg + afk_pkg::qmul(c3c4_reg, a_s2_reg);
            c1s2s4_reg <= afk_pkg::qmul(c1s2_reg, a_s4_reg);
            s1s2s4_reg <= afk_pkg::qmul(s1s2_reg, a_s4_reg);
            s2s3s5_reg <= afk_pkg::qmul(s2s3_reg, a_s5_reg);
            c5s2s3_reg <= afk_pkg::qmul(c5s2_reg, a_s3_reg);
            c1c4s2_reg <= afk_pkg::qmul(c1c4_reg, a_s2_reg);
            c4s1s2_reg <= afk_pkg::qmul(c4s1_reg, a_s2_reg);
            o8_b_reg   <= c2c4_reg - afk_pkg::qmul(c3s2_reg, a_s4_reg);
            b_s4_reg   <= a_s4_reg;
            b_c4_reg   <= a_c4_reg;
            b_s5_reg   <= a_s5_reg;
            b_c5_reg   <= a_c5_reg;
            px_b_reg   <= afk_pkg::lmul(offset_len, c1c2_reg)
                        - afk_pkg::lmul(reach_len, c1s2_reg);
            py_b_reg   <= afk_pkg::lmul(offset_len, c2s1_reg)
                        - afk_pkg::lmul(reach_len, s1s2_reg);
            pz_b_reg   <= pz_a_reg;
        end
    end

    // Stage 3: wrist-pitch terms
    q_t tf_reg, tg_reg, o6_reg, o7_reg, tb_c_reg, td_c_reg, te_c_reg;
    q_t s2s3s5_c_reg, c5s2s3_c_reg, o8_c_reg, c_s5_reg, c_c5_reg;
    pw_t px_c_reg, py_c_reg, pz_c_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            tf_reg       <= afk_pkg::qmul(b_c4_reg, ta_reg) + c1s2s4_reg;
            tg_reg       <= afk_pkg::qmul(b_c4_reg, tc_reg) - s1s2s4_reg;
            o6_reg       <= afk_pkg::qmul(b_s4_reg, ta_reg) - c1c4s2_reg;
            o7_reg       <= -afk_pkg::qmul(b_s4_reg, tc_reg) - c4s1s2_reg;
            tb_c_reg     <= tb_reg;
            td_c_reg     <= td_reg;
            te_c_reg     <= te_reg;
            s2s3s5_c_reg <= s2s3s5_reg;
            c5s2s3_c_reg <= c5s2s3_reg;
            o8_c_reg     <= o8_b_reg;
            c_s5_reg     <= b_s5_reg;
            c_c5_reg     <= b_c5_reg;
            px_c_reg     <= px_b_reg;
            py_c_reg     <= py_b_reg;
            pz_c_reg     <= pz_b_reg;
        end
    end

    // Stage 4: wrist-roll terms
    afk_pkg::raw_t raw_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            raw_reg.o[0] <= -afk_pkg::qmul(c_c5_reg, tf_reg)
                          - afk_pkg::qmul(c_s5_reg, tb_c_reg);
            raw_reg.o[1] <= afk_pkg::qmul(c_c5_reg, tg_reg)
                          + afk_pkg::qmul(c_s5_reg, td_c_reg);
            raw_reg.o[2] <= afk_pkg::qmul(c_c5_reg, te_c_reg) - s2s3s5_c_reg;
            raw_reg.o[3] <= afk_pkg::qmul(c_s5_reg, tf_reg)
                          - afk_pkg::qmul(c_c5_reg, tb_c_reg);
            raw_reg.o[4] <= afk_pkg::qmul(c_c5_reg, td_c_reg)
                          - afk_pkg::qmul(c_s5_reg, tg_reg);
            raw_reg.o[5] <= -afk_pkg::qmul(c_s5_reg, te_c_reg) - c5s2s3_c_reg;
            raw_reg.o[6] <= o6_reg;
            raw_reg.o[7] <= o7_reg;
            raw_reg.o[8] <= o8_c_reg;
            raw_reg.p[0] <= px_c_reg;
            raw_reg.p[1] <= py_c_reg;
            raw_reg.p[2] <= pz_c_reg;
        end
    end

    assign raw = raw_reg;

endmodule
`default_nettype wire

// ===== src/arm_forward_kinematics_5dof.sv =====
// Top level: five CORDIC lanes, pose merge, rounding and saturating output register.
// Depends on afk_pkg, afk_cordic and afk_pose.
//
//  channel   | direction | handshake             | payload
//  s_        | in        | s_valid / s_ready     | five joint angles
//  m_        | out       | m_valid / m_ready     | nine unit-vector terms, three positions
//  cfg_      | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request per cycle while the pipeline advances, through the CORDIC lanes, pose merge and output register.
// The whole pipeline advances when the output register is empty or being taken.
// Reset clears valid bits and restores both link lengths; cfg_ready is always high.
`default_nettype none
module arm_forward_kinematics_5dof #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire logic signed [ANGLE_BITS-1:0]   s_joint_one,
    input  wire logic signed [ANGLE_BITS-1:0]   s_joint_two,
    input  wire logic signed [ANGLE_BITS-1:0]   s_joint_three,
    input  wire logic signed [ANGLE_BITS-1:0]   s_joint_four,
    input  wire logic signed [ANGLE_BITS-1:0]   s_joint_five,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic signed [FRAC_BITS+1:0]         m_normal_x,
    output logic signed [FRAC_BITS+1:0]         m_normal_y,
    output logic signed [FRAC_BITS+1:0]         m_normal_z,
    output logic signed [FRAC_BITS+1:0]         m_orient_x,
    output logic signed [FRAC_BITS+1:0]         m_orient_y,
    output logic signed [FRAC_BITS+1:0]         m_orient_z,
    output logic signed [FRAC_BITS+1:0]         m_approach_x,
    output logic signed [FRAC_BITS+1:0]         m_approach_y,
    output logic signed [FRAC_BITS+1:0]         m_approach_z,
    output logic signed [afk_pkg::POS_WIDTH-1:0] m_pos_x,
    output logic signed [afk_pkg::POS_WIDTH-1:0] m_pos_y,
    output logic signed [afk_pkg::POS_WIDTH-1:0] m_pos_z,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [afk_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [afk_pkg::LEN_W-1:0]      cfg_data
);

    localparam int LAT    = afk_pkg::CORDIC_STEPS + 2 + 4;
    localparam int UW     = FRAC_BITS + 2;
    localparam int PWID   = afk_pkg::POS_WIDTH;
    localparam int USHIFT = 30 - FRAC_BITS;

    // Configuration registers
    afk_pkg::len_t offset_reg, reach_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= afk_pkg::OFFSET_RESET;
            reach_reg  <= afk_pkg::REACH_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == afk_pkg::CFG_OFFSET) begin
                offset_reg <= cfg_data;
            end else if (cfg_index == afk_pkg::CFG_REACH) begin
                reach_reg <= cfg_data;
            end
        end
    end

    // Pipeline advance
    logic en;
    logic m_valid_reg;
    logic [LAT-1:0] vld_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[LAT-2:0], s_valid};
            m_valid_reg <= vld_reg[LAT-1];
        end
    end

    // Sine/cosine lanes
    logic [ANGLE_BITS-1:0] joints [0:4];
    afk_pkg::sc_t lane_sc [0:4];

    assign joints[0] = s_joint_one;
    assign joints[1] = s_joint_two;
    assign joints[2] = s_joint_three;
    assign joints[3] = s_joint_four;
    assign joints[4] = s_joint_five;

    for (genvar j = 0; j < 5; j++) begin : g_lane
        afk_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
            .aclk  (aclk),
            .en    (en),
            .angle (joints[j]),
            .sc    (lane_sc[j])
        );
    end

    afk_pkg::raw_t raw;

    afk_pose u_pose (
        .aclk       (aclk),
        .en         (en),
        .lane       (lane_sc),
        .offset_len (offset_reg),
        .reach_len  (reach_reg),
        .raw        (raw)
    );

    // Round Q30 to Q2.FRAC_BITS and saturate to unit range
    function automatic logic [UW-1:0] unit_out(input afk_pkg::q_t v);
        afk_pkg::q_t r;
        r = (v + (afk_pkg::q_t'(1) <<< (USHIFT - 1))) >>> USHIFT;
        if (r > (afk_pkg::q_t'(1) <<< FRAC_BITS)) begin
            r = afk_pkg::q_t'(1) <<< FRAC_BITS;
        end else if (r < -(afk_pkg::q_t'(1) <<< FRAC_BITS)) begin
            r = -(afk_pkg::q_t'(1) <<< FRAC_BITS);
        end
        return r[UW-1:0];
    endfunction

    // Round length-times-Q30 to integer and saturate to the position range
    function automatic logic [PWID-1:0] pos_out(input afk_pkg::pw_t v);
        afk_pkg::pw_t r;
        r = (v + (afk_pkg::pw_t'(1) <<< 29)) >>> 30;
        if (r > ((afk_pkg::pw_t'(1) <<< (PWID - 1)) - 1)) begin
            r = (afk_pkg::pw_t'(1) <<< (PWID - 1)) - 1;
        end else if (r < -(afk_pkg::pw_t'(1) <<< (PWID - 1))) begin
            r = -(afk_pkg::pw_t'(1) <<< (PWID - 1));
        end
        return r[PWID-1:0];
    endfunction

    // Output register
    logic [UW-1:0]   unit_reg [0:8];
    logic [PWID-1:0] pos_reg  [0:2];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) begin
                unit_reg[k] <= unit_out(raw.o[k]);
            end
            for (int k = 0; k < 3; k++) begin
                pos_reg[k] <= pos_out(raw.p[k]);
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_normal_x   = unit_reg[0];
    assign m_normal_y   = unit_reg[1];
    assign m_normal_z   = unit_reg[2];
    assign m_orient_x   = unit_reg[3];
    assign m_orient_y   = unit_reg[4];
    assign m_orient_z   = unit_reg[5];
    assign m_approach_x = unit_reg[6];
    assign m_approach_y = unit_reg[7];
    assign m_approach_z = unit_reg[8];
    assign m_pos_x      = pos_reg[0];
    assign m_pos_y      = pos_reg[1];
    assign m_pos_z      = pos_reg[2];

endmodule
`default_nettype wire

// ===== tb/arm_forward_kinematics_5dof_test.sv =====
// Self-checking testbench for arm_forward_kinematics_5dof: a CORDIC-based pose predictor,
// a queue-fed driver, a stalling monitor and link-length reprogramming between phases.
// Depends on afk_pkg and the arm_forward_kinematics_5dof RTL.
`default_nettype none
module arm_forward_kinematics_5dof_test;

    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        logic signed [15:0] j [5];
    } joints_t;

    typedef struct {
        logic signed [15:0] vec [9];
        logic signed [17:0] pos [3];
    } pose_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_joint [5];
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [15:0] m_vec [9];
    logic signed [17:0] m_pos [3];
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [afk_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [afk_pkg::LEN_W-1:0] cfg_data = '0;

    joints_t pending_joints [$];
    pose_t   expected_poses [$];
    longint  offset_len = 10240;
    longint  reach_len = 39117;
    int      mismatches = 0;
    int      joints_sent = 0;
    int      quiet_cycles = 0;
    bit      no_idle = 1'b0;
    bit      long_hold_done = 1'b0;

    initial for (int k = 0; k < 5; k++) s_joint[k] = '0;

    always #4 aclk = ~aclk;

    arm_forward_kinematics_5dof i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_joint_one(s_joint[0]), .s_joint_two(s_joint[1]), .s_joint_three(s_joint[2]),
        .s_joint_four(s_joint[3]), .s_joint_five(s_joint[4]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_normal_x(m_vec[0]), .m_normal_y(m_vec[1]), .m_normal_z(m_vec[2]),
        .m_orient_x(m_vec[3]), .m_orient_y(m_vec[4]), .m_orient_z(m_vec[5]),
        .m_approach_x(m_vec[6]), .m_approach_y(m_vec[7]), .m_approach_z(m_vec[8]),
        .m_pos_x(m_pos[0]), .m_pos_y(m_pos[1]), .m_pos_z(m_pos[2]),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Arctangent steps, 2^32 per turn
    localparam logic [31:0] ATAN_STEP [30] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint mul30(longint a, longint b);
        return rnd_shift(a * b, 30);
    endfunction

    // Sine and cosine in Q30; angles in the two middle quadrants are rotated by pi
    function automatic void joint_sin_cos(logic [15:0] ang, output longint sn, output longint cs);
        logic [31:0] z;
        logic        flip;
        longint      x, y, dx, dy;
        z = {ang, 16'h0000};
        flip = (z[31:30] == 2'd1) || (z[31:30] == 2'd2);
        x = 652032874;
        y = 0;
        if (flip) z = z + 32'h80000000;
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z[31]) begin
                x = x + dx; y = y - dy; z = z + ATAN_STEP[i];
            end else begin
                x = x - dx; y = y + dy; z = z - ATAN_STEP[i];
            end
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endfunction

    function automatic logic signed [15:0] to_unit(longint q);
        longint v;
        v = rnd_shift(q, 16);
        if (v < -16384) v = -16384;
        if (v > 16384) v = 16384;
        return v[15:0];
    endfunction

    function automatic logic signed [17:0] to_pos(longint q);
        longint v;
        v = rnd_shift(q, 30);
        if (v < -131072) v = -131072;
        if (v > 131071) v = 131071;
        return v[17:0];
    endfunction

    // End-effector pose for one joint vector under the current link lengths
    function automatic pose_t arm_pose(joints_t jv);
        pose_t  p;
        longint sn [5], cs [5];
        longint ta, tb, tc, td, te, tf, tg;
        for (int k = 0; k < 5; k++) joint_sin_cos(jv.j[k], sn[k], cs[k]);
        ta = mul30(sn[0], sn[2]) - mul30(mul30(cs[0], cs[1]), cs[2]);
        tb = mul30(cs[2], sn[0]) + mul30(mul30(cs[0], cs[1]), sn[2]);
        tc = mul30(cs[0], sn[2]) + mul30(mul30(cs[1], cs[2]), sn[0]);
        td = mul30(cs[0], cs[2]) - mul30(mul30(cs[1], sn[0]), sn[2]);
        te = mul30(cs[1], sn[3]) + mul30(mul30(cs[2], cs[3]), sn[1]);
        tf = mul30(cs[3], ta) + mul30(mul30(cs[0], sn[1]), sn[3]);
        tg = mul30(cs[3], tc) - mul30(mul30(sn[0], sn[1]), sn[3]);
        p.vec[0] = to_unit(-mul30(cs[4], tf) - mul30(sn[4], tb));
        p.vec[1] = to_unit(mul30(cs[4], tg) + mul30(sn[4], td));
        p.vec[2] = to_unit(mul30(cs[4], te) - mul30(mul30(sn[1], sn[2]), sn[4]));
        p.vec[3] = to_unit(mul30(sn[4], tf) - mul30(cs[4], tb));
        p.vec[4] = to_unit(mul30(cs[4], td) - mul30(sn[4], tg));
        p.vec[5] = to_unit(-mul30(sn[4], te) - mul30(mul30(cs[4], sn[1]), sn[2]));
        p.vec[6] = to_unit(mul30(sn[3], ta) - mul30(mul30(cs[0], cs[3]), sn[1]));
        p.vec[7] = to_unit(-mul30(sn[3], tc) - mul30(mul30(cs[3], sn[0]), sn[1]));
        p.vec[8] = to_unit(mul30(cs[1], cs[3]) - mul30(mul30(cs[2], sn[1]), sn[3]));
        p.pos[0] = to_pos(offset_len * mul30(cs[0], cs[1]) - reach_len * mul30(cs[0], sn[1]));
        p.pos[1] = to_pos(offset_len * mul30(cs[1], sn[0]) - reach_len * mul30(sn[0], sn[1]));
        p.pos[2] = to_pos(reach_len * cs[1] + offset_len * sn[1]);
        return p;
    endfunction

    // Driver: one request per free slot, random gap bursts
    int send_gap = 0;
    always @(posedge aclk) begin
        logic    nxt_valid;
        joints_t jv;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            nxt_valid = s_valid;
            if (s_valid && s_ready) begin
                for (int k = 0; k < 5; k++) jv.j[k] = s_joint[k];
                expected_poses.push_back(arm_pose(jv));
                joints_sent++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_joints.size() > 0) begin
                    jv = pending_joints.pop_front();
                    for (int k = 0; k < 5; k++) s_joint[k] <= jv.j[k];
                    nxt_valid = 1'b1;
                    if (!no_idle && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 4);
                end
            end
            s_valid <= nxt_valid;
        end
    end

    // Monitor: checks each result and stalls the result channel
    int stall_left = 0;
    always @(posedge aclk) begin
        pose_t exp_p;
        bit    bad;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_poses.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected pose at %0t", $realtime);
                end else begin
                    exp_p = expected_poses.pop_front();
                    bad = 1'b0;
                    for (int k = 0; k < 9; k++) if (m_vec[k] !== exp_p.vec[k]) bad = 1'b1;
                    for (int k = 0; k < 3; k++) if (m_pos[k] !== exp_p.pos[k]) bad = 1'b1;
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            for (int k = 0; k < 9; k++)
                                $display("  vec[%0d] exp %0d got %0d", k, exp_p.vec[k], m_vec[k]);
                            for (int k = 0; k < 3; k++)
                                $display("  pos[%0d] exp %0d got %0d", k, exp_p.pos[k], m_pos[k]);
                        end
                    end
                end
            end
            // one long hold to back the pipeline up into the input
            if (!long_hold_done && joints_sent >= 150) begin
                long_hold_done = 1'b1;
                stall_left = 300;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 4);
            end
        end
    end

    // Watchdog on handshake activity
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void add_joints(int a, int b, int c, int d, int e);
        joints_t jv;
        jv.j[0] = a[15:0]; jv.j[1] = b[15:0]; jv.j[2] = c[15:0];
        jv.j[3] = d[15:0]; jv.j[4] = e[15:0];
        pending_joints.push_back(jv);
    endfunction

    // Mostly uniform angles, some near the quadrant boundaries
    function automatic int pick_angle();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 3) * 16384 + $urandom_range(0, 8) - 4;
        return $urandom_range(0, 65535);
    endfunction

    function automatic void add_random(int n);
        for (int i = 0; i < n; i++)
            add_joints(pick_angle(), pick_angle(), pick_angle(), pick_angle(), pick_angle());
    endfunction

    task automatic drain();
        while (pending_joints.size() > 0 || s_valid || expected_poses.size() > 0)
            @(posedge aclk);
        repeat (45) @(posedge aclk);
    endtask

    task automatic write_reg(logic [afk_pkg::CFG_IDX_W-1:0] idx,
                             logic [afk_pkg::LEN_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == afk_pkg::CFG_OFFSET) offset_len = val;
        else if (idx == afk_pkg::CFG_REACH) reach_len = val;
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, -pi, quadrant points, default lengths
        add_joints(0, 0, 0, 0, 0);
        add_joints(32767, 32767, 32767, 32767, 32767);
        add_joints(-32768, -32768, -32768, -32768, -32768);
        add_joints(16384, 16384, 16384, 16384, 16384);
        add_joints(-16384, -16384, -16384, -16384, -16384);
        add_joints(8192, -8192, 8192, -8192, 8192);
        add_joints(-32768, 0, 16384, -16384, 32767);
        add_joints(0, 16384, 0, 16384, 0);
        add_joints(0, -16384, -32768, 0, 16384);
        add_joints(16383, 16385, -16383, -16385, 1);
        add_joints(-1, 1, -1, 1, -1);
        add_joints(-32767, 32767, -32768, 0, -32768);
        add_joints(5461, 10923, -5461, -10923, 21845);
        add_random(110);
        drain();

        // zero offset, full reach; out-of-range index is ignored
        write_reg(afk_pkg::CFG_OFFSET, 16'd0);
        write_reg(afk_pkg::CFG_REACH, 16'hFFFF);
        write_reg(8'd2, 16'h1234);
        write_reg(8'hFF, 16'hFFFF);
        add_joints(0, 0, 0, 0, 0);
        add_joints(0, 16384, 0, 0, 0);
        add_random(80);
        drain();

        // both lengths at full scale: largest positions, still inside the output range
        write_reg(afk_pkg::CFG_OFFSET, 16'hFFFF);
        add_joints(0, 8192, 0, 0, 0);
        add_joints(-32768, -8192, 0, 0, 0);
        add_joints(8192, 8192, 0, 0, 0);
        add_random(80);
        drain();

        // random lengths, then zero reach
        write_reg(afk_pkg::CFG_OFFSET, afk_pkg::len_t'($urandom_range(0, 65535)));
        write_reg(afk_pkg::CFG_REACH, afk_pkg::len_t'($urandom_range(0, 65535)));
        add_random(60);
        drain();
        write_reg(afk_pkg::CFG_REACH, 16'd0);
        add_random(20);
        drain();

        // back to defaults, no idling in the final stretch
        write_reg(afk_pkg::CFG_OFFSET, afk_pkg::OFFSET_RESET);
        write_reg(afk_pkg::CFG_REACH, afk_pkg::REACH_RESET);
        no_idle = 1'b1;
        add_random(90);
        drain();

        if (mismatches == 0 && expected_poses.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== arm_forward_kinematics_5dof.f =====
src/afk_pkg.sv
src/afk_cordic.sv
src/afk_pose.sv
src/arm_forward_kinematics_5dof.sv
tb/arm_forward_kinematics_5dof_test.sv
